// File: hw/rtl/signal_strength_to_cnr_estimator_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef SIGNAL_STRENGTH_TO_CNR_ESTIMATOR_UNIT_ASSERT_SVH
`define SIGNAL_STRENGTH_TO_CNR_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SSCNR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSCNR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/sscnr_pkg.sv
// ----------------------------------------------------------------------------
// sscnr_pkg
// Constants, coefficient table and shared types of the CNR estimator.
// ----------------------------------------------------------------------------
package sscnr_pkg;

	localparam int CNR_FRAC_BITS = 8;
	localparam int ACC_W         = 48;
	localparam int MAG_W         = 44;
	localparam int HALF_W        = MAG_W / 2;
	localparam int P_W           = 24;
	localparam int MUL_W         = 32;
	localparam int SQ_W          = 42;
	localparam int LOG_ITERS     = 16;
	localparam int SQRT_ITERS    = 21;
	localparam int TERR_STEPS    = 4;
	localparam int SAT_STEPS     = 5;

	localparam logic [20:0] LOG2_REF_Q16    = 21'd1467503;
	localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;
	localparam logic [15:0] SAT_OFFSET      = 16'd3000;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} core_stat_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOG    = 7'b0000010,
		ST_PCALC  = 7'b0000100,
		ST_SQRT   = 7'b0001000,
		ST_MLO    = 7'b0010000,
		ST_MHI    = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	// polynomial coefficients, Q.32, highest power first
	function automatic logic signed [ACC_W-1:0] coef_at(input logic sat, input logic [2:0] idx);
		logic signed [ACC_W-1:0] c;
		c = '0;
		case ({sat, idx})
			4'b0_000: c = 48'sd103079;
			4'b0_001: c = -48'sd6871948;
			4'b0_010: c = 48'sd170939698;
			4'b0_011: c = 48'sd2358366542;
			4'b0_100: c = 48'sd13299366232;
			4'b1_000: c = -48'sd7020553542;
			4'b1_001: c = 48'sd61594125992;
			4'b1_010: c = -48'sd215860761330;
			4'b1_011: c = 48'sd382153305096;
			4'b1_100: c = -48'sd384678745866;
			4'b1_101: c = 48'sd252788890141;
			default:  c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/sscnr_mul.sv
// ----------------------------------------------------------------------------
// sscnr_mul
// Shared unsigned 32x32 multiplier used for log squaring, scaling and Horner.
// ----------------------------------------------------------------------------
module sscnr_mul import sscnr_pkg::*; (
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] p
);

	assign p = a * b;

endmodule

// File: hw/rtl/sscnr_core.sv
// ----------------------------------------------------------------------------
// sscnr_core
// Sequencer and datapath: log2 or square root, then Horner on one multiplier.
// ----------------------------------------------------------------------------
module sscnr_core import sscnr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        sat_mode,
	input  logic [15:0] raw,
	input  logic        take,
	output core_stat_t  stat,
	output logic [15:0] res_cnr
);

	localparam logic [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (31 - CNR_FRAC_BITS);

	state_t state_q;
	logic [4:0]  cnt_q;
	logic [2:0]  step_q;
	logic        sat_q;
	logic [3:0]  n_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [P_W-1:0] p_q;
	logic [SQ_W-1:0] v_q, res_q, bit_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [HALF_W+P_W-1:0] plo_q;

	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] mul_p;
	logic [3:0]  lead_n;
	logic [32:0] sq;
	logic        sq_ge;
	logic [20:0] d;
	logic [2*MUL_W-1:0] pround;
	logic [SQ_W-1:0] trial;
	logic        sq_take;
	logic [ACC_W-1:0] acc_mag;
	logic        acc_neg;
	logic [85:0] hsum;
	logic [ACC_W-1:0] r48, rnd_s;
	logic [15:0] sat_s;
	logic [ACC_W-1:0] rv, shifted;
	logic [2:0]  last_step;

	sscnr_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

	always_comb begin
		lead_n = '0;
		for (int i = 0; i < 16; i++) begin
			if (raw[i]) lead_n = 4'(i);
		end
	end

	assign sq      = mul_p[62:30];
	assign sq_ge   = |sq[32:31];
	assign d       = LOG2_REF_Q16 - {1'b0, n_q, frac_q};
	assign pround  = mul_p + 64'd32768;
	assign trial   = res_q + bit_q;
	assign sq_take = v_q >= trial;
	assign acc_neg = acc_q[ACC_W-1];
	assign acc_mag = acc_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign hsum    = {mul_p, {HALF_W{1'b0}}} + 86'(plo_q) + 86'd32768;
	assign r48     = hsum[ACC_W+15:16];
	assign rnd_s   = acc_neg ? (~r48 + 1'b1) : r48;
	assign sat_s   = (raw > SAT_OFFSET) ? (raw - SAT_OFFSET) : 16'd0;
	assign last_step = sat_q ? 3'(SAT_STEPS) : 3'(TERR_STEPS);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_LOG: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			ST_PCALC: begin
				mul_a = 32'(d);
				mul_b = 32'(TEN_LOG10_2_Q16);
			end
			ST_MLO: begin
				mul_a = 32'(acc_mag[HALF_W-1:0]);
				mul_b = 32'(p_q);
			end
			ST_MHI: begin
				mul_a = 32'(acc_mag[MAG_W-1:HALF_W]);
				mul_b = 32'(p_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up, then saturate
	always_comb begin
		rv      = acc_q + OUT_HALF;
		shifted = rv >> (32 - CNR_FRAC_BITS);
		if (acc_neg) res_cnr = '0;
		else if (|shifted[ACC_W-1:16]) res_cnr = 16'hFFFF;
		else res_cnr = shifted[15:0];
	end

	assign stat.busy      = state_q != ST_IDLE;
	assign stat.res_valid = state_q == ST_FINISH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						sat_q  <= sat_mode;
						cnt_q  <= '0;
						step_q <= 3'd1;
						state_q <= sat_mode ? ST_SQRT : ST_LOG;
					end
				end
				ST_LOG: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(LOG_ITERS - 1)) state_q <= ST_PCALC;
				end
				ST_PCALC: state_q <= ST_MLO;
				ST_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SQRT_ITERS - 1)) state_q <= ST_MLO;
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: begin
					step_q <= step_q + 3'd1;
					state_q <= (step_q == last_step) ? ST_FINISH : ST_MLO;
				end
				ST_FINISH: begin
					if (take) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				acc_q  <= coef_at(sat_mode, 3'd0);
				n_q    <= lead_n;
				m_q    <= 31'({15'b0, raw}) << (5'd30 - {1'b0, lead_n});
				frac_q <= '0;
				v_q    <= {6'b0, sat_s, 20'b0};
				res_q  <= '0;
				bit_q  <= SQ_W'(1) << 40;
			end
			ST_LOG: begin
				m_q    <= sq_ge ? sq[31:1] : sq[30:0];
				frac_q <= {frac_q[14:0], sq_ge};
			end
			ST_PCALC: p_q <= pround[P_W+15:16];
			ST_SQRT: begin
				if (sq_take) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
					p_q   <= P_W'((res_q >> 1) + bit_q);
				end else begin
					res_q <= res_q >> 1;
					p_q   <= P_W'(res_q >> 1);
				end
				bit_q <= bit_q >> 2;
			end
			ST_MLO: plo_q <= mul_p[HALF_W+P_W-1:0];
			ST_MHI: acc_q <= $signed(rnd_s) + coef_at(sat_q, step_q);
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/signal_strength_to_cnr_estimator_unit.sv
// ----------------------------------------------------------------------------
// signal_strength_to_cnr_estimator_unit
// Raw tuner strength to CNR estimate (Q8.8 dB) with running min and max.
// ----------------------------------------------------------------------------
// Sequence: in terrestrial mode, 16 log2 squarings on the shared multiplier,
//   scaling, 4 Horner steps (each a low-half then a high-half multiply),
//   output load; in satellite mode, 21 root steps, 5 Horner steps, output load.
//   The result waits in the core while the output stalls. A zero reading: none.
// Flow: in_stall holds off a new reading until the previous result is taken.
// Reset: async active low; mode terrestrial, min all ones, max zero.
module signal_strength_to_cnr_estimator_unit import sscnr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] raw_strength,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] cnr_db,
	output logic [15:0] cnr_min_db,
	output logic [15:0] cnr_max_db
);

	logic        sat_mode_q;
	logic        out_valid_q;
	logic [15:0] cnr_q, min_q, max_q;
	core_stat_t  stat;
	logic [15:0] res_cnr;
	logic        start, take;
	logic [15:0] min_n, max_n;

	assign in_stall = stat.busy;
	assign start    = in_valid && !stat.busy && (raw_strength != 16'd0);
	assign take     = stat.res_valid && (!out_valid_q || !out_stall);
	assign min_n    = (res_cnr < min_q) ? res_cnr : min_q;
	assign max_n    = (res_cnr > max_q) ? res_cnr : max_q;

	sscnr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.sat_mode (sat_mode_q),
		.raw      (raw_strength),
		.take     (take),
		.stat     (stat),
		.res_cnr  (res_cnr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
			min_q       <= 16'hFFFF;
			max_q       <= '0;
		end else begin
			if (cfg_wr_en) sat_mode_q <= cfg_wr_data;
			if (take) begin
				out_valid_q <= 1'b1;
				min_q       <= min_n;
				max_q       <= max_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) cnr_q <= res_cnr;
	end

	assign out_valid  = out_valid_q;
	assign cnr_db     = cnr_q;
	assign cnr_min_db = min_q;
	assign cnr_max_db = max_q;

endmodule

// File: hw/rtl/sscnr_checker.sv
// ----------------------------------------------------------------------------
// sscnr_checker
// Port-level checks of the CNR estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "signal_strength_to_cnr_estimator_unit_assert.svh"

module sscnr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] raw_strength,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] cnr_db,
	input logic [15:0] cnr_min_db,
	input logic [15:0] cnr_max_db
);

	// stalled result holds
	`SSCNR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(cnr_db), "stalled result changed")

	// estimate lies within the tracked range
	`SSCNR_ASSERT_IMP(a_range, clk, arst_n, out_valid, (cnr_min_db <= cnr_db) && (cnr_db <= cnr_max_db), "estimate outside min/max")

	// nonzero request keeps the sequencer busy
	`SSCNR_ASSERT_NXT(a_busy, clk, arst_n, in_valid && !in_stall && (raw_strength != 16'd0), in_stall, "not busy after request")

endmodule

bind signal_strength_to_cnr_estimator_unit sscnr_checker u_sscnr_checker (.*);
